// ===== design/gpb_pkg.sv =====
// gpb_pkg: shared constants and types for the glyph pixel blender
// used by the top level and the port checker; no dependencies
package gpb_pkg;

  // font store size in bytes, a power of two; addresses wrap at this size
  localparam int FONT_BYTES = 16384;
  localparam int FONT_AW    = $clog2(FONT_BYTES);
  // width of the font address arithmetic before wrapping
  localparam int FADDR_W    = 24;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  localparam int GW_W    = 5;
  localparam int GH_W    = 6;
  localparam int SCALE_W = 12;
  localparam int FRAME_W = 12;
  localparam int PIX_W   = 32;
  localparam int PADDR_W = 22;
  localparam int CELL_W  = 12;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_DRAW = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GLYPH_WIDTH  = 3'd0,
    REG_GLYPH_HEIGHT = 3'd1,
    REG_INV_SCALE    = 3'd2,
    REG_TEXT_COLOR   = 3'd3,
    REG_BACK_COLOR   = 3'd4,
    REG_FRAME_WIDTH  = 3'd5,
    REG_FRAME_HEIGHT = 3'd6,
    REG_FRAME_PITCH  = 3'd7
  } cfg_idx_t;

  localparam logic [GW_W-1:0]    RST_GLYPH_WIDTH  = 5'd8;
  localparam logic [GH_W-1:0]    RST_GLYPH_HEIGHT = 6'd14;
  localparam logic [SCALE_W-1:0] RST_INV_SCALE    = 12'd256;
  localparam logic [PIX_W-1:0]   RST_TEXT_COLOR   = 32'hFFFF_FFFF;
  localparam logic [PIX_W-1:0]   RST_BACK_COLOR   = 32'hFF00_0000;
  localparam logic [FRAME_W-1:0] RST_FRAME_WIDTH  = 12'd960;
  localparam logic [FRAME_W-1:0] RST_FRAME_HEIGHT = 12'd544;
  localparam logic [FRAME_W-1:0] RST_FRAME_PITCH  = 12'd960;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

endpackage

// ===== design/gpb_ram.sv =====
// gpb_ram: generic single-write, single-read memory with registered read
// no dependencies
module gpb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/glyph_pixel_blender.sv =====
// glyph_pixel_blender: text overlay pixel engine, font store plus colour blend
// depends on gpb_pkg and gpb_ram
// a draw transaction passes stages 1, 2 and 3 and then the output register before its result shows
// throughput: one transaction per cycle while the output is not stalled; four register stages share one stall enable
// load transactions write the font store in stage 2 and give no result
// reset (synchronous, active low) clears valid bits and loads register defaults, not the font store
module glyph_pixel_blender (
  input  logic                         clk,
  input  logic                         rst_n,

  // configuration write port
  input  logic                         cfg_we,
  input  logic [gpb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gpb_pkg::CFG_DATA_W-1:0] cfg_data,

  // input transaction channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_command,
  input  logic [13:0]                  in_font_address,
  input  logic [7:0]                   in_font_data,
  input  logic [7:0]                   in_char_code,
  input  logic [10:0]                  in_origin_x,
  input  logic [10:0]                  in_origin_y,
  input  logic [7:0]                   in_offset_x,
  input  logic [7:0]                   in_offset_y,
  input  logic [31:0]                  in_old_pixel,

  // result transaction channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_write_enable,
  output logic [21:0]                  out_pixel_address,
  output logic [31:0]                  out_pixel_value,
  output logic                         out_out_of_frame
);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [gpb_pkg::GW_W-1:0]    glyph_width_r;
  logic [gpb_pkg::GH_W-1:0]    glyph_height_r;
  logic [gpb_pkg::SCALE_W-1:0] inv_scale_r;
  logic [gpb_pkg::PIX_W-1:0]   text_color_r;
  logic [gpb_pkg::PIX_W-1:0]   back_color_r;
  logic [gpb_pkg::FRAME_W-1:0] frame_width_r;
  logic [gpb_pkg::FRAME_W-1:0] frame_height_r;
  logic [gpb_pkg::FRAME_W-1:0] frame_pitch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glyph_width_r  <= gpb_pkg::RST_GLYPH_WIDTH;
      glyph_height_r <= gpb_pkg::RST_GLYPH_HEIGHT;
      inv_scale_r    <= gpb_pkg::RST_INV_SCALE;
      text_color_r   <= gpb_pkg::RST_TEXT_COLOR;
      back_color_r   <= gpb_pkg::RST_BACK_COLOR;
      frame_width_r  <= gpb_pkg::RST_FRAME_WIDTH;
      frame_height_r <= gpb_pkg::RST_FRAME_HEIGHT;
      frame_pitch_r  <= gpb_pkg::RST_FRAME_PITCH;
    end else if (cfg_we) begin
      unique case (gpb_pkg::cfg_idx_t'(cfg_index))
        gpb_pkg::REG_GLYPH_WIDTH:  glyph_width_r  <= cfg_data[gpb_pkg::GW_W-1:0];
        gpb_pkg::REG_GLYPH_HEIGHT: glyph_height_r <= cfg_data[gpb_pkg::GH_W-1:0];
        gpb_pkg::REG_INV_SCALE:    inv_scale_r    <= cfg_data[gpb_pkg::SCALE_W-1:0];
        gpb_pkg::REG_TEXT_COLOR:   text_color_r   <= cfg_data[gpb_pkg::PIX_W-1:0];
        gpb_pkg::REG_BACK_COLOR:   back_color_r   <= cfg_data[gpb_pkg::PIX_W-1:0];
        gpb_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_data[gpb_pkg::FRAME_W-1:0];
        gpb_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_data[gpb_pkg::FRAME_W-1:0];
        gpb_pkg::REG_FRAME_PITCH:  frame_pitch_r  <= cfg_data[gpb_pkg::FRAME_W-1:0];
      endcase
    end
  end

  // bytes per font row: one per started group of eight columns
  logic [gpb_pkg::GW_W-1:0] glyph_width_m1;
  logic [2:0]               bytes_per_row;

  assign glyph_width_m1 = glyph_width_r - gpb_pkg::GW_W'(1);
  assign bytes_per_row  = {1'b0, glyph_width_m1[4:3]} + 3'd1;

  // ---------------------------------------------------------------------------
  // pipeline advance: every stage moves when the output register is free
  // ---------------------------------------------------------------------------
  logic out_valid_r;
  logic advance;

  assign advance  = !out_valid_r || out_ready;
  assign in_ready = advance;

  // ---------------------------------------------------------------------------
  // stage 1: scale offsets into font cells, frame position, char row base
  // ---------------------------------------------------------------------------
  logic [19:0] scaled_x;
  logic [19:0] scaled_y;

  logic                           s1_valid_r;
  gpb_pkg::cmd_t                  s1_cmd_r;
  logic [gpb_pkg::FONT_AW-1:0]    s1_load_addr_r;
  logic [7:0]                     s1_load_data_r;
  logic [gpb_pkg::CELL_W-1:0]     s1_fx_r;
  logic [gpb_pkg::CELL_W-1:0]     s1_fy_r;
  logic [11:0]                    s1_col_r;
  logic [11:0]                    s1_row_r;
  logic [13:0]                    s1_chgh_r;
  logic [31:0]                    s1_old_r;

  // q4.8 reciprocal multiply stands in for the division by the text scale
  assign scaled_x = 20'(in_offset_x) * 20'(inv_scale_r);
  assign scaled_y = 20'(in_offset_y) * 20'(inv_scale_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_cmd_r       <= gpb_pkg::cmd_t'(in_command);
      s1_load_addr_r <= gpb_pkg::FONT_AW'(gpb_pkg::FADDR_W'(in_font_address));
      s1_load_data_r <= in_font_data;
      s1_fx_r        <= scaled_x[19:8];
      s1_fy_r        <= scaled_y[19:8];
      s1_col_r       <= 12'(in_origin_x) + 12'(in_offset_x);
      s1_row_r       <= 12'(in_origin_y) + 12'(in_offset_y);
      s1_chgh_r      <= 14'(in_char_code) * 14'(glyph_height_r);
      s1_old_r       <= in_old_pixel;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: font store access, glyph and frame clipping, pixel address
  // ---------------------------------------------------------------------------
  logic [gpb_pkg::FADDR_W-1:0] font_addr_full;
  logic [gpb_pkg::FONT_AW-1:0] font_raddr;
  logic                        font_we;
  logic [7:0]                  font_byte;
  logic [24:0]                 pix_addr_full;

  // row base times bytes per row plus the byte that holds the column
  assign font_addr_full = (gpb_pkg::FADDR_W'(s1_chgh_r) + gpb_pkg::FADDR_W'(s1_fy_r))
                          * gpb_pkg::FADDR_W'(bytes_per_row)
                          + gpb_pkg::FADDR_W'(s1_fx_r[11:3]);
  // store size is a power of two, so the wrap is a truncation
  assign font_raddr     = font_addr_full[gpb_pkg::FONT_AW-1:0];
  assign font_we        = advance && s1_valid_r && (s1_cmd_r == gpb_pkg::CMD_LOAD);
  assign pix_addr_full  = 25'(s1_col_r) + 25'(s1_row_r) * 25'(frame_pitch_r);

  // loads and reads pass this port in transaction order, so a draw sees every
  // earlier load
  gpb_ram #(
    .WIDTH (8),
    .DEPTH (gpb_pkg::FONT_BYTES)
  ) u_font_ram (
    .clk   (clk),
    .we    (font_we),
    .waddr (s1_load_addr_r),
    .wdata (s1_load_data_r),
    .re    (advance),
    .raddr (font_raddr),
    .rdata (font_byte)
  );

  logic        s2_valid_r;
  logic        s2_in_glyph_r;
  logic        s2_in_frame_r;
  logic [21:0] s2_paddr_r;
  logic [2:0]  s2_bit_r;
  logic [31:0] s2_old_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (advance) begin
      // load transactions leave the pipeline here
      s2_valid_r <= s1_valid_r && (s1_cmd_r == gpb_pkg::CMD_DRAW);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_in_glyph_r <= (s1_fx_r < gpb_pkg::CELL_W'(glyph_width_r))
                    && (s1_fy_r < gpb_pkg::CELL_W'(glyph_height_r));
      s2_in_frame_r <= (s1_col_r < frame_width_r) && (s1_row_r < frame_height_r);
      s2_paddr_r    <= pix_addr_full[21:0];
      s2_bit_r      <= s1_fx_r[2:0];
      s2_old_r      <= s1_old_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: pick text or background colour from the font bit, msb leftmost
  // ---------------------------------------------------------------------------
  logic font_bit;

  assign font_bit = font_byte[~s2_bit_r];

  logic        s3_valid_r;
  logic        s3_in_glyph_r;
  logic        s3_in_frame_r;
  logic [21:0] s3_paddr_r;
  logic [31:0] s3_color_r;
  logic [31:0] s3_old_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (advance) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_in_glyph_r <= s2_in_glyph_r;
      s3_in_frame_r <= s2_in_frame_r;
      s3_paddr_r    <= s2_paddr_r;
      s3_color_r    <= font_bit ? text_color_r : back_color_r;
      s3_old_r      <= s2_old_r;
    end
  end

  // ---------------------------------------------------------------------------
  // output stage: alpha handling and blend over the old pixel
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] mix_over(input logic [31:0] color,
                                           input logic [31:0] old);
    logic [7:0]  a;
    logic [7:0]  na;
    logic [15:0] acc;
    logic [31:0] res;
    a   = color[31:24];
    na  = gpb_pkg::ALPHA_OPAQUE - a;
    res = {gpb_pkg::ALPHA_OPAQUE, 24'd0};
    for (int ch = 0; ch < 3; ch++) begin
      // sum never exceeds 255 * 255, so 16 bits hold it
      acc = 16'(a) * 16'(color[ch*8 +: 8]) + 16'(na) * 16'(old[ch*8 +: 8]);
      res[ch*8 +: 8] = acc[15:8];
    end
    return res;
  endfunction

  logic [7:0]  alpha;
  logic        hit;
  logic        we_nxt;
  logic [31:0] value_nxt;

  assign alpha  = s3_color_r[31:24];
  assign hit    = s3_in_glyph_r && s3_in_frame_r;
  assign we_nxt = hit && (alpha != gpb_pkg::ALPHA_CLEAR);

  always_comb begin
    priority if (!we_nxt) begin
      value_nxt = '0;
    end else if (alpha == gpb_pkg::ALPHA_OPAQUE) begin
      value_nxt = s3_color_r;
    end else begin
      value_nxt = mix_over(s3_color_r, s3_old_r);
    end
  end

  logic        out_we_r;
  logic [21:0] out_addr_r;
  logic [31:0] out_value_r;
  logic        out_oof_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_we_r    <= we_nxt;
      // pixels outside the glyph or the frame report address zero
      out_addr_r  <= hit ? s3_paddr_r : '0;
      out_value_r <= value_nxt;
      out_oof_r   <= s3_in_glyph_r && !s3_in_frame_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_write_enable  = out_we_r;
  assign out_pixel_address = out_addr_r;
  assign out_pixel_value   = out_value_r;
  assign out_out_of_frame  = out_oof_r;

endmodule

// ===== design/gpb_checker.sv =====
// gpb_checker: port-level checks on the glyph pixel blender, bound to the top
// depends on gpb_pkg and glyph_pixel_blender
module gpb_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           cfg_we,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           out_write_enable,
  input logic [gpb_pkg::PADDR_W-1:0]    out_pixel_address,
  input logic [gpb_pkg::PIX_W-1:0]      out_pixel_value,
  input logic                           out_out_of_frame
);

  // a stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_write_enable)
      && $stable(out_pixel_address) && $stable(out_pixel_value)
      && $stable(out_out_of_frame))
    else $error("result changed while stalled");

  // input side only stalls when a result waits
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with free output");

  // a clipped pixel is never written and carries address zero
  a_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_frame |-> !out_write_enable && (out_pixel_address == '0))
    else $error("clipped pixel written or addressed");

  // an unwritten pixel carries value zero
  a_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_write_enable |-> out_pixel_value == '0)
    else $error("value given without write");

  // registers must only change while no transaction is offered or waiting; the block itself does not enforce this
  a_cfg_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |-> !in_valid && !out_valid)
    else $error("configuration written while transactions pending");

endmodule

bind glyph_pixel_blender gpb_checker u_gpb_checker (.*);
